@@ rtl/transfer_stats_rate_meter_defines.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef TRANSFER_STATS_RATE_METER_DEFINES_SVH
`define TRANSFER_STATS_RATE_METER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSRM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tsrm_pkg.sv @@
package tsrm_pkg;

  localparam int DATA_W             = 64;
  localparam int SEC_W              = 32;
  localparam int KIND_W             = 3;
  localparam int OUTCOME_W          = 2;
  localparam int IN_TDATA_W         = 72;
  localparam int CNT_N              = 7;
  localparam int CIDX_W             = 3;
  localparam int OUT_TDATA_W        = DATA_W * (CNT_N + 1);
  localparam int BITS_SHIFT         = 3;
  localparam int DEF_NUM_BUCKETS    = 16;
  localparam int DEF_WINDOW_SECONDS = 10;

  typedef logic [DATA_W-1:0]    word_t;
  typedef logic [CIDX_W-1:0]    cidx_t;
  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [OUTCOME_W-1:0] outcome_t;

  localparam kind_t KIND_REQ    = 3'd0;
  localparam kind_t KIND_START  = 3'd1;
  localparam kind_t KIND_BYTES  = 3'd2;
  localparam kind_t KIND_FINISH = 3'd3;
  localparam kind_t KIND_FAIL   = 3'd4;
  localparam kind_t KIND_TICK   = 3'd5;
  localparam kind_t KIND_SNAP   = 3'd6;
  localparam kind_t KIND_CLEAR  = 3'd7;

  localparam cidx_t CNT_REQ     = 3'd0;
  localparam cidx_t CNT_ACTIVE  = 3'd1;
  localparam cidx_t CNT_DONE    = 3'd2;
  localparam cidx_t CNT_ABORT   = 3'd3;
  localparam cidx_t CNT_TIMEOUT = 3'd4;
  localparam cidx_t CNT_FAIL    = 3'd5;
  localparam cidx_t CNT_BYTES   = 3'd6;

  // Divider handshake between the sequencer and the divide unit.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic word_t sat_add(word_t a, word_t b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? '1 : s[DATA_W-1:0];
  endfunction

  // Outcomes map in order onto the completed, aborted, timed out and failed counters.
  function automatic cidx_t outcome_cnt(outcome_t o);
    return CNT_DONE + {1'b0, o};
  endfunction

endpackage

@@ rtl/tsrm_ram.sv @@
module tsrm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tsrm_div.sv @@
module tsrm_div #(
  parameter int DW = 64,
  parameter int VW = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DW-1:0]         dividend,
  input  logic [VW-1:0]         divisor,
  output tsrm_pkg::div_status_t status,
  output logic [DW-1:0]         quotient
);

  import tsrm_pkg::*;

  localparam int IW = $clog2(DW);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] quo;
  logic [IW-1:0] iter;
  logic          busy;
  logic          done;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  assign trial = {rem, quo[DW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == IW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[VW-1:0] : trial[VW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

@@ rtl/transfer_stats_rate_meter.sv @@
// Channel  Direction  tdata                                      tuser
// s_       in         byte_count[63:0], outcome[65:64]           kind[2:0]
// m_       out        requests .. total_bytes, bits_per_second   none
//
// Counting events, ticks and clears pass through ST_EXEC; a nonzero byte event passes through
// ST_BYTES and ST_BKT because it reads and rewrites its bucket in the bucket RAM.
// A snapshot makes one bucket RAM read per cycle into the shared saturating adder, then
// runs a 64-step shift-subtract division.
// Reset is synchronous; bucket valid bits sit in flip-flops.
// A snapshot result waits in the output register and the next snapshot holds until it
// is taken.
`include "transfer_stats_rate_meter_defines.svh"

module transfer_stats_rate_meter #(
  parameter int NUM_BUCKETS    = tsrm_pkg::DEF_NUM_BUCKETS,
  parameter int WINDOW_SECONDS = tsrm_pkg::DEF_WINDOW_SECONDS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // byte_count[63:0], outcome[65:64], zero fill above
  input  logic [tsrm_pkg::IN_TDATA_W-1:0]    s_tdata,
  // kind[2:0]
  input  logic [tsrm_pkg::KIND_W-1:0]        s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // requests, active, completed, aborted, timed_out, failed, total_bytes,
  // bits_per_second, 64 bits each from the lowest bits up
  output logic [tsrm_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  import tsrm_pkg::*;

  localparam int AW    = $clog2(NUM_BUCKETS);
  localparam int CW    = $clog2(NUM_BUCKETS + 1);
  localparam int WIN_W = $clog2(WINDOW_SECONDS + 1);
  localparam int RAM_W = SEC_W + DATA_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_BYTES = 3'd2;
  localparam logic [2:0] ST_BKT   = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_BITS  = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]             state;
  word_t                  counters [CNT_N];
  logic [SEC_W-1:0]       now_second;
  logic [AW-1:0]          now_idx;
  logic [SEC_W-1:0]       start_second;
  logic                   start_known;
  logic [NUM_BUCKETS-1:0] bkt_valid;
  logic [CW-1:0]          cnt;

  kind_t                  kind_r;
  word_t                  nbytes_r;
  outcome_t               outcome_r;
  word_t                  acc;
  logic [AW-1:0]          rd_idx;

  cidx_t                  sel;
  word_t                  add_a;
  word_t                  add_b;
  word_t                  add_sum;

  logic                   ram_we;
  logic [AW-1:0]          ram_raddr;
  logic [RAM_W-1:0]       ram_wdata;
  logic [RAM_W-1:0]       ram_rdata;
  word_t                  rd_bytes;
  logic [SEC_W-1:0]       rd_tag;
  logic [SEC_W-1:0]       age;
  logic                   in_win;
  logic                   stale;

  logic [SEC_W:0]         elapsed;
  logic [WIN_W-1:0]       window;
  word_t                  bits;
  logic                   div_start;
  div_status_t            div_st;
  word_t                  quotient;
  logic                   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign rd_bytes = ram_rdata[DATA_W-1:0];
  assign rd_tag   = ram_rdata[RAM_W-1:DATA_W];
  assign age      = now_second - rd_tag;
  assign in_win   = bkt_valid[rd_idx] && (age < SEC_W'(WINDOW_SECONDS));
  assign stale    = !bkt_valid[now_idx] || (rd_tag != now_second);

  assign ram_raddr = (state == ST_SUM) ? cnt[AW-1:0] : now_idx;
  assign ram_we    = (state == ST_BKT);
  assign ram_wdata = {now_second, add_sum};

  assign elapsed = start_known ? ({1'b0, now_second - start_second} + (SEC_W+1)'(1))
                               : (SEC_W+1)'(1);
  assign window  = (elapsed < (SEC_W+1)'(WINDOW_SECONDS)) ? elapsed[WIN_W-1:0]
                                                          : WIN_W'(WINDOW_SECONDS);
  assign bits    = (|acc[DATA_W-1:DATA_W-BITS_SHIFT]) ? '1
                                                      : {acc[DATA_W-BITS_SHIFT-1:0],
                                                         BITS_SHIFT'(0)};
  assign div_start = (state == ST_BITS);

  always_comb begin
    unique case (kind_r)
      KIND_REQ:    sel = CNT_REQ;
      KIND_START:  sel = CNT_ACTIVE;
      KIND_FINISH: sel = outcome_cnt(outcome_r);
      default:     sel = CNT_FAIL;
    endcase
  end

  // One saturating adder serves every accumulation in the block.
  always_comb begin
    add_a = '0;
    add_b = '0;
    unique case (state)
      ST_EXEC: begin
        add_a = counters[sel];
        add_b = DATA_W'(1);
      end
      ST_BYTES: begin
        add_a = counters[CNT_BYTES];
        add_b = nbytes_r;
      end
      ST_BKT: begin
        add_a = stale ? '0 : rd_bytes;
        add_b = nbytes_r;
      end
      ST_SUM: begin
        add_a = acc;
        add_b = in_win ? rd_bytes : '0;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_sum = sat_add(add_a, add_b);

  tsrm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_BUCKETS)
  ) u_bkt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (now_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tsrm_div #(
    .DW (DATA_W),
    .VW (WIN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (bits),
    .divisor  (window),
    .status   (div_st),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      now_second   <= '0;
      now_idx      <= '0;
      start_second <= '0;
      start_known  <= 1'b0;
      bkt_valid    <= '0;
      cnt          <= '0;
      for (int i = 0; i < CNT_N; i++) begin
        counters[i] <= '0;
      end
    end else begin
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (s_tvalid) begin
            if (s_tuser == KIND_SNAP) begin
              state <= ST_SUM;
            end else if (s_tuser == KIND_BYTES && s_tdata[DATA_W-1:0] != '0) begin
              state <= ST_BYTES;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          unique case (kind_r)
            KIND_REQ, KIND_START, KIND_FAIL: begin
              counters[sel] <= add_sum;
            end
            KIND_FINISH: begin
              counters[sel] <= add_sum;
              if (counters[CNT_ACTIVE] != '0) begin
                counters[CNT_ACTIVE] <= counters[CNT_ACTIVE] - DATA_W'(1);
              end
            end
            KIND_TICK: begin
              now_second <= now_second + SEC_W'(1);
              if (now_second == '1 || now_idx == AW'(NUM_BUCKETS - 1)) begin
                now_idx <= '0;
              end else begin
                now_idx <= now_idx + AW'(1);
              end
            end
            KIND_CLEAR: begin
              for (int i = 0; i < CNT_N; i++) begin
                counters[i] <= '0;
              end
              bkt_valid    <= '0;
              start_second <= now_second;
              start_known  <= 1'b1;
            end
            default: begin
            end
          endcase
        end
        ST_BYTES: begin
          counters[CNT_BYTES] <= add_sum;
          state <= ST_BKT;
        end
        ST_BKT: begin
          bkt_valid[now_idx] <= 1'b1;
          state <= ST_IDLE;
        end
        ST_SUM: begin
          if (cnt == CW'(NUM_BUCKETS)) begin
            state <= ST_BITS;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_BITS: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_st.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      kind_r    <= s_tuser;
      nbytes_r  <= s_tdata[DATA_W-1:0];
      outcome_r <= s_tdata[DATA_W+OUTCOME_W-1:DATA_W];
      acc       <= '0;
    end
    if (state == ST_SUM) begin
      rd_idx <= cnt[AW-1:0];
      if (cnt != '0) begin
        acc <= add_sum;
      end
    end
    if (state == ST_DONE && out_free) begin
      m_tdata <= {quotient, counters[6], counters[5], counters[4], counters[3],
                  counters[2], counters[1], counters[0]};
    end
  end

  `TSRM_ASSERT_SAME(a_div_done_waited, clk, rst, div_st.done, state == ST_DIV, "divide finished outside the divide wait")
  `TSRM_ASSERT_SAME(a_div_idle_start, clk, rst, div_start, !div_st.busy, "divide started while busy")
  `TSRM_ASSERT_SAME(a_bkt_after_read, clk, rst, state == ST_BKT, $past(state) == ST_BYTES, "bucket update without a bucket read")
  `TSRM_ASSERT_NEXT(a_done_holds, clk, rst, state == ST_DONE && m_tvalid && !m_tready, state == ST_DONE, "snapshot result left while output busy")
  `TSRM_ASSERT_NEXT(a_snap_sweeps, clk, rst, s_tvalid && s_tready && s_tuser == KIND_SNAP, state == ST_SUM && cnt == '0, "snapshot did not start a bucket sweep")

endmodule

@@ tb/sv/tb_transfer_stats_rate_meter.sv @@
`timescale 1ns / 100ps

module tb_transfer_stats_rate_meter;
  import tsrm_pkg::*;

  localparam int unsigned NB  = DEF_NUM_BUCKETS;
  localparam int unsigned WIN = DEF_WINDOW_SECONDS;
  localparam int ITEMS        = 1800;
  localparam int LIMIT_NS     = 20_000_000;

  localparam outcome_t OUTCOME_DONE    = 2'd0;
  localparam outcome_t OUTCOME_ABORT   = 2'd1;
  localparam outcome_t OUTCOME_TIMEOUT = 2'd2;
  localparam outcome_t OUTCOME_FAILED  = 2'd3;

  typedef struct packed {
    kind_t    kind;
    word_t    nbytes;
    outcome_t oc;
  } event_t;

  // Field i of a snapshot sits at bits [64*i +: 64], requests first.
  typedef logic [CNT_N:0][DATA_W-1:0] snapshot_t;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [KIND_W-1:0]      s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  event_t    pending[$];
  snapshot_t snapshot_q[$];

  word_t             cnt[CNT_N];
  logic [SEC_W-1:0]  now_sec;
  logic [SEC_W-1:0]  start_sec;
  logic              start_known;
  word_t             bkt_bytes[NB];
  logic [SEC_W-1:0]  bkt_tag[NB];
  logic              bkt_valid[NB];

  int   mismatches   = 0;
  int   results_seen = 0;
  int   gap_left     = 0;
  int   hold_left    = 0;
  int   tx_calm      = 0;
  int   rx_calm      = 0;
  logic holdoff      = 1'b0;

  string field_names[CNT_N+1] = '{"requests", "active", "completed", "aborted",
                                  "timed_out", "failed", "total_bytes",
                                  "bits_per_second"};

  transfer_stats_rate_meter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic word_t sat_sum(word_t a, word_t b);
    return (b > ~a) ? '1 : a + b;
  endfunction

  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_stats();
    for (int i = 0; i < CNT_N; i++) begin
      cnt[i] = '0;
    end
    for (int i = 0; i < NB; i++) begin
      bkt_bytes[i] = '0;
      bkt_tag[i]   = '0;
      bkt_valid[i] = 1'b0;
    end
  endtask

  function automatic word_t window_rate();
    word_t            sum;
    word_t            bits;
    word_t            elapsed;
    word_t            span;
    logic [SEC_W-1:0] age;
    sum = '0;
    for (int i = 0; i < NB; i++) begin
      age = now_sec - bkt_tag[i];
      if (bkt_valid[i] && age < WIN) begin
        sum = sat_sum(sum, bkt_bytes[i]);
      end
    end
    bits    = (sum[63:61] != 3'b0) ? '1 : {sum[60:0], 3'b000};
    elapsed = start_known ? {32'b0, SEC_W'(now_sec - start_sec)} + 64'd1 : 64'd1;
    span    = (elapsed < WIN) ? elapsed : word_t'(WIN);
    return bits / span;
  endfunction

  task automatic apply_event(kind_t kind, word_t nbytes, outcome_t oc);
    int unsigned slot;
    snapshot_t   snap;
    slot = now_sec % NB;
    case (kind)
      KIND_REQ: begin
        cnt[CNT_REQ] = sat_sum(cnt[CNT_REQ], 64'd1);
      end
      KIND_START: begin
        cnt[CNT_ACTIVE] = sat_sum(cnt[CNT_ACTIVE], 64'd1);
      end
      KIND_BYTES: begin
        if (nbytes != '0) begin
          cnt[CNT_BYTES] = sat_sum(cnt[CNT_BYTES], nbytes);
          if (!bkt_valid[slot] || bkt_tag[slot] != now_sec) begin
            bkt_bytes[slot] = '0;
            bkt_tag[slot]   = now_sec;
            bkt_valid[slot] = 1'b1;
          end
          bkt_bytes[slot] = sat_sum(bkt_bytes[slot], nbytes);
        end
      end
      KIND_FINISH: begin
        if (cnt[CNT_ACTIVE] != '0) begin
          cnt[CNT_ACTIVE] = cnt[CNT_ACTIVE] - 64'd1;
        end
        case (oc)
          OUTCOME_DONE:    cnt[CNT_DONE]    = sat_sum(cnt[CNT_DONE], 64'd1);
          OUTCOME_ABORT:   cnt[CNT_ABORT]   = sat_sum(cnt[CNT_ABORT], 64'd1);
          OUTCOME_TIMEOUT: cnt[CNT_TIMEOUT] = sat_sum(cnt[CNT_TIMEOUT], 64'd1);
          default:         cnt[CNT_FAIL]    = sat_sum(cnt[CNT_FAIL], 64'd1);
        endcase
      end
      KIND_FAIL: begin
        cnt[CNT_FAIL] = sat_sum(cnt[CNT_FAIL], 64'd1);
      end
      KIND_TICK: begin
        now_sec = now_sec + 1'b1;
      end
      KIND_SNAP: begin
        for (int i = 0; i < CNT_N; i++) begin
          snap[i] = cnt[i];
        end
        snap[CNT_N] = window_rate();
        snapshot_q.push_back(snap);
      end
      default: begin
        clear_stats();
        start_sec   = now_sec;
        start_known = 1'b1;
      end
    endcase
  endtask

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic add(kind_t kind, word_t nbytes = '0, outcome_t oc = OUTCOME_DONE);
    event_t e;
    e.kind   = kind;
    e.nbytes = nbytes;
    e.oc     = oc;
    pending.push_back(e);
  endtask

  function automatic word_t rand_bytes();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 8) return {$urandom, $urandom};
    if (r < 10) return '1 - $urandom_range(0, 3);
    if (r < 20) return {24'b0, 8'($urandom), $urandom};
    return word_t'($urandom_range(1, 1 << 20));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
      clear_stats();
      now_sec     = '0;
      start_sec   = '0;
      start_known = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_event(s_tuser, s_tdata[63:0], s_tdata[65:64]);
        gap_left = pick_idle(tx_calm);
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0 || pending.size() == 0) begin
          if (gap_left != 0) gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= {6'b0, pending[0].oc, pending[0].nbytes};
          s_tuser  <= pending[0].kind;
          void'(pending.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        hold_left = pick_idle(rx_calm);
      end else if (hold_left == 0 && $urandom_range(0, 15) == 0) begin
        hold_left = pick_idle(rx_calm);
      end
      if (holdoff) begin
        m_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (snapshot_q.size() == 0) begin
        report("snapshot result with no snapshot request pending");
      end else begin
        for (int i = 0; i <= CNT_N; i++) begin
          if (m_tdata[i*DATA_W +: DATA_W] !== snapshot_q[0][i]) begin
            report($sformatf("%s: got %h, expected %h", field_names[i],
                             m_tdata[i*DATA_W +: DATA_W], snapshot_q[0][i]));
          end
        end
        void'(snapshot_q.pop_front());
      end
    end
  end

  // The receiver holds off for a long stretch once, so snapshots back up.
  initial begin
    while (results_seen < 3) @(posedge clk);
    holdoff <= 1'b1;
    repeat (1500) @(posedge clk);
    holdoff <= 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_transfer_stats_rate_meter failed");
    $finish;
  end

  initial begin
    int n;
    int r;
    n = 0;

    add(KIND_SNAP);
    add(KIND_REQ);
    add(KIND_START);
    add(KIND_FINISH, '0, OUTCOME_DONE);
    add(KIND_FINISH, '0, OUTCOME_ABORT);
    add(KIND_START);
    add(KIND_FINISH, '0, OUTCOME_TIMEOUT);
    add(KIND_FINISH, '0, OUTCOME_FAILED);
    add(KIND_FAIL);
    add(KIND_BYTES, '0);
    add(KIND_BYTES, 64'd1);
    add(KIND_BYTES, '1);
    add(KIND_SNAP);
    add(KIND_CLEAR);
    add(KIND_BYTES, 64'd1000);
    add(KIND_TICK);
    add(KIND_BYTES, 64'h1fff_ffff_ffff_ffff);
    add(KIND_SNAP);
    repeat (9) add(KIND_TICK);
    add(KIND_SNAP);

    while (n < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        add(KIND_REQ);
        add(KIND_START);
        n += 2;
        if ($urandom_range(0, 3) == 0) begin
          add(KIND_START);
          n++;
        end
        repeat ($urandom_range(1, 4)) begin
          add(KIND_BYTES, rand_bytes());
          n++;
        end
        if ($urandom_range(0, 3) == 0) begin
          add(KIND_TICK);
          n++;
        end
        if ($urandom_range(0, 7) == 0) begin
          add(KIND_FAIL);
          n++;
        end
        add(KIND_FINISH, rand_bytes(), outcome_t'($urandom_range(0, 3)));
        n++;
      end else if (r < 65) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(8, 20)) begin
            add(KIND_TICK);
            n++;
          end
        end else begin
          add(KIND_TICK);
          n++;
        end
      end else if (r < 80) begin
        add(KIND_SNAP, rand_bytes(), outcome_t'($urandom_range(0, 3)));
        n++;
      end else if (r < 88) begin
        add(kind_t'($urandom_range(0, 7)), {$urandom, $urandom},
            outcome_t'($urandom_range(0, 3)));
        n++;
      end else if (r < 90) begin
        add(KIND_CLEAR);
        n++;
      end else begin
        add(KIND_BYTES, rand_bytes());
        n++;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || s_tvalid || snapshot_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_transfer_stats_rate_meter passed");
    end else begin
      $display("tb_transfer_stats_rate_meter failed");
    end
    $finish;
  end

endmodule
